/* src/oist_pkg.sv */
`timescale 1ns / 1ps
package oist_pkg;

  localparam int unsigned MaxRangesDef = 16;
  localparam int unsigned LineBitsDef  = 32;
  localparam int unsigned DocBits      = 32;
  localparam int unsigned LangBits     = 4;
  localparam int unsigned FieldBits    = 32;
  localparam int unsigned CountBits    = 5;

  typedef enum logic [1:0] {
    OP_REMEMBER   = 2'd0,
    OP_INVALIDATE = 2'd1,
    OP_QUERY      = 2'd2,
    OP_CLEAR      = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [DocBits-1:0]   document_id;
    logic [LangBits-1:0]  language;
    logic [FieldBits-1:0] start_line;
    logic [FieldBits-1:0] end_line;
  } req_t;

  typedef struct packed {
    logic                 covered;
    logic                 table_full;
    logic [CountBits-1:0] range_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request, reset walk index
    logic scan;     // process one stored entry
    logic finish;   // commit new set (remember, invalidate) and latch the result
    logic clear;    // empty set, zero owner
    logic take_own; // replace owner from request, empty set
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;
    logic owner_match;
    logic empty_req;
  } dp_sts_t;

endpackage

/* src/owned_interval_set_tracker.sv */
`timescale 1ns / 1ps
// Channel | Ports                        | Beat marker
// ------- | ---------------------------- | ------------------------------
// request | req_i (oist_pkg::req_t)      | start high while busy low
// result  | rsp_o (oist_pkg::rsp_t)      | done_o high for one cycle
// When no walk is needed (clear, empty remember, invalidate or query with owner
// mismatch) the controller goes from ST_IDLE straight to ST_OUT, the result beat;
// otherwise it passes ST_WALK, one stored range per cycle, and ST_FIN between them.
// Reset empties the set and zeroes the owner; no clearing pass.
// The receiver cannot stall; busy stays high through the result beat.
module owned_interval_set_tracker #(
  parameter int unsigned MaxRanges = oist_pkg::MaxRangesDef,
  parameter int unsigned LineBits  = oist_pkg::LineBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  oist_pkg::req_t req_i,
  output logic           done_o,
  output oist_pkg::rsp_t rsp_o
);
  import oist_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  oist_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .opcode_i(req_i.opcode),
    .sts_i(sts), .cmd_o(cmd), .busy_o(busy), .done_o
  );

  oist_datapath #(.MaxRanges(MaxRanges), .LineBits(LineBits)) u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .sts_o(sts), .rsp_o
  );
endmodule

/* src/oist_datapath.sv */
`timescale 1ns / 1ps
module oist_datapath #(
  parameter int unsigned MaxRanges = oist_pkg::MaxRangesDef,
  parameter int unsigned LineBits  = oist_pkg::LineBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  oist_pkg::req_t   req_i,
  input  oist_pkg::dp_cmd_t cmd_i,
  output oist_pkg::dp_sts_t sts_o,
  output oist_pkg::rsp_t   rsp_o
);
  import oist_pkg::*;

  localparam int unsigned IdxBits = (MaxRanges > 1) ? $clog2(MaxRanges) : 1;
  localparam int unsigned CntBits = $clog2(MaxRanges + 1);

  // stored set, double-banked: walk reads bank rd_q, writes the other bank
  logic [LineBits-1:0] beg_q [2][MaxRanges];
  logic [LineBits-1:0] fin_q [2][MaxRanges];
  logic                rd_q;
  logic [CntBits-1:0]  cnt_q;
  logic [DocBits-1:0]  own_doc_q;
  logic [LangBits-1:0] own_lang_q;

  logic [1:0]          op_q;
  logic [LineBits-1:0] s_q, e_q;
  logic [CntBits-1:0]  idx_q;   // read index
  logic [CntBits-1:0]  w_q;     // write count
  logic                pend_q;  // new range not yet written (remember)
  logic                merg_q;  // pending range absorbed something
  logic                reach_done_q, fail_q;
  logic [LineBits-1:0] reach_q;
  logic                full_q;
  rsp_t                rsp_q;

  logic [LineBits-1:0] rs, re, cb, cf;
  logic [IdxBits-1:0]  ri, wi;
  logic                wr_bank;
  assign rs = LineBits'(req_i.start_line);
  assign re = LineBits'(req_i.end_line);
  assign ri = idx_q[IdxBits-1:0];
  assign wi = w_q[IdxBits-1:0];
  assign wr_bank = ~rd_q;
  assign cb = beg_q[rd_q][ri];
  assign cf = fin_q[rd_q][ri];

  assign sts_o.walk_done   = (idx_q == cnt_q);
  assign sts_o.owner_match = (own_doc_q == req_i.document_id) &&
                             (own_lang_q == req_i.language);
  assign sts_o.empty_req   = !(re > rs);
  assign rsp_o = rsp_q;

  // final entry count (written, stored entries left, pending range), to detect overflow
  logic [CntBits:0] need;
  assign need = {1'b0, w_q} + {1'b0, cnt_q} - {1'b0, idx_q} + (CntBits+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; cnt_q <= '0; own_doc_q <= '0; own_lang_q <= '0;
      idx_q <= '0; w_q <= '0; pend_q <= 1'b0; merg_q <= 1'b0;
      full_q <= 1'b0; rsp_q <= '0; op_q <= '0;
      reach_done_q <= 1'b0; fail_q <= 1'b0;
      s_q <= '0; e_q <= '0; reach_q <= '0;
    end else begin
      if (cmd_i.take_own) begin
        own_doc_q <= req_i.document_id; own_lang_q <= req_i.language;
        cnt_q <= '0;
      end
      if (cmd_i.clear) begin
        own_doc_q <= '0; own_lang_q <= '0; cnt_q <= '0;
      end
      // capture request
      if (cmd_i.load) begin
        op_q <= req_i.opcode; s_q <= rs; e_q <= re;
        idx_q <= '0; w_q <= '0; pend_q <= 1'b1; merg_q <= 1'b0;
        full_q <= 1'b0; reach_q <= rs; reach_done_q <= !(re > rs);
        fail_q <= 1'b0;
      end
      // walk one entry
      if (cmd_i.scan) begin
        idx_q <= idx_q + CntBits'(1);
        case (op_q)
          OP_REMEMBER: begin
            if (pend_q && cb <= e_q && cf >= s_q) begin
              // absorb entry into pending range
              if (cb < s_q) s_q <= cb;
              if (cf > e_q) e_q <= cf;
              merg_q <= 1'b1;
            end else if (pend_q && cb > e_q) begin
              // emit pending range then this entry
              beg_q[wr_bank][wi] <= s_q; fin_q[wr_bank][wi] <= e_q;
              pend_q <= 1'b0;
              if (!merg_q && need > (CntBits+1)'(MaxRanges)) full_q <= 1'b1;
              if (w_q + CntBits'(1) < CntBits'(MaxRanges)) begin
                beg_q[wr_bank][IdxBits'(w_q + CntBits'(1))] <= cb;
                fin_q[wr_bank][IdxBits'(w_q + CntBits'(1))] <= cf;
              end
              w_q <= w_q + CntBits'(2);
            end else begin
              beg_q[wr_bank][wi] <= cb; fin_q[wr_bank][wi] <= cf;
              w_q <= w_q + CntBits'(1);
            end
          end
          OP_INVALIDATE: begin
            if (cf <= s_q) begin
              beg_q[wr_bank][wi] <= cb; fin_q[wr_bank][wi] <= cf;
              w_q <= w_q + CntBits'(1);
            end else if (cb < s_q) begin
              beg_q[wr_bank][wi] <= cb; fin_q[wr_bank][wi] <= s_q;
              w_q <= w_q + CntBits'(1);
            end
          end
          default: begin
            // coverage: advance reach
            if (!reach_done_q && !fail_q && cf > reach_q) begin
              if (cb > reach_q) fail_q <= 1'b1;
              else begin
                reach_q <= cf;
                if (cf >= e_q) reach_done_q <= 1'b1;
              end
            end
          end
        endcase
      end
      // commit and report
      if (cmd_i.finish) begin
        case (op_q)
          OP_REMEMBER: begin
            if (pend_q) begin
              if (w_q < CntBits'(MaxRanges)) begin
                beg_q[wr_bank][wi] <= s_q; fin_q[wr_bank][wi] <= e_q;
                cnt_q <= w_q + CntBits'(1); rd_q <= wr_bank;
              end else full_q <= 1'b1;
            end else if (full_q) begin
              // overflow: keep old bank
            end else begin
              cnt_q <= w_q; rd_q <= wr_bank;
            end
            rsp_q.covered <= 1'b0;
            rsp_q.table_full <= (pend_q && !(w_q < CntBits'(MaxRanges))) || full_q;
            rsp_q.range_count <= (pend_q && (w_q < CntBits'(MaxRanges))) ?
                                 CountBits'(w_q + CntBits'(1)) :
                                 (full_q || pend_q) ? CountBits'(cnt_q) :
                                 CountBits'(w_q);
          end
          OP_INVALIDATE: begin
            cnt_q <= w_q; rd_q <= wr_bank;
            rsp_q <= '{covered: 1'b0, table_full: 1'b0,
                       range_count: CountBits'(w_q)};
          end
          default: begin
            rsp_q <= '{covered: reach_done_q && !fail_q, table_full: 1'b0,
                       range_count: CountBits'(cnt_q)};
          end
        endcase
      end
      // report without walk (no-op remember, failed query, mismatch invalidate, clear)
      if (cmd_i.load) rsp_q <= '{covered: 1'b0, table_full: 1'b0,
                                 range_count: cmd_i.clear ? CountBits'(0) :
                                              CountBits'(cnt_q)};
    end
  end

endmodule

/* src/oist_ctrl.sv */
`timescale 1ns / 1ps
module oist_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        opcode_i,
  input  oist_pkg::dp_sts_t sts_i,
  output oist_pkg::dp_cmd_t cmd_o,
  output logic              busy_o,
  output logic              done_o
);
  import oist_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   acc;
  assign acc = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          cmd_o.load = 1'b1;
          state_d = ST_OUT;
          case (op_e'(opcode_i))
            OP_REMEMBER: if (!sts_i.empty_req) begin
              cmd_o.take_own = !sts_i.owner_match;
              state_d = ST_WALK;
            end
            OP_INVALIDATE: begin
              if (sts_i.owner_match) state_d = ST_WALK;
              else cmd_o.clear = 1'b1;
            end
            OP_QUERY: if (sts_i.owner_match) state_d = ST_WALK;
            default: cmd_o.clear = 1'b1;
          endcase
        end
      end
      // walk one stored entry per cycle
      ST_WALK: begin
        if (sts_i.walk_done) state_d = ST_FIN;
        else cmd_o.scan = 1'b1;
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end
endmodule
